// File: rtl/tlds_pkg.sv
// shared constants, codes and types of the torque limited direction sequencer
package tlds_pkg;

   // hold counter width and hold lengths in ticks
   localparam int unsigned CNT_W = 12;
   localparam logic [CNT_W-1:0] HOLD_TICKS_SPEED  = 12'd3000;
   localparam logic [CNT_W-1:0] HOLD_TICKS_TOGGLE = 12'd350;

   // negative side scale, 1066/1024 (about 1.041)
   localparam logic [10:0] NEG_SCALE = 11'd1066;
   localparam int unsigned NEG_SHIFT = 10;

   // lower threshold floor
   localparam logic [15:0] LOW_LIMIT_MIN = 16'd36;

   // item op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // run status codes
   localparam logic [1:0] ST_STOP  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_FWD   = 2'd2;
   localparam logic [1:0] ST_REV   = 2'd3;

   // command kinds
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   // drive modes of a run command
   localparam logic [1:0] DRV_SPEED  = 2'd0;
   localparam logic [1:0] DRV_TOGGLE = 2'd2;

   // sustained current flags
   localparam logic [1:0] FLAG_NONE = 2'd0;
   localparam logic [1:0] FLAG_HIGH = 2'd1;
   localparam logic [1:0] FLAG_LOW  = 2'd2;

   // run modes
   localparam logic [2:0] MODE_TOGGLE   = 3'd0;
   localparam logic [2:0] MODE_SPD_REV  = 3'd1;
   localparam logic [2:0] MODE_SPD_FWD  = 3'd2;
   localparam logic [2:0] MODE_KEEP_FWD = 3'd3;
   localparam logic [2:0] MODE_KEEP_REV = 3'd4;

   // register indexes
   localparam logic [2:0] REG_RUN_MODE   = 3'd0;
   localparam logic [2:0] REG_FWD_SPEED  = 3'd1;
   localparam logic [2:0] REG_REV_SPEED  = 3'd2;
   localparam logic [2:0] REG_OSC_SPEED  = 3'd3;
   localparam logic [2:0] REG_FWD_TARGET = 3'd4;
   localparam logic [2:0] REG_REV_TARGET = 3'd5;
   localparam logic [2:0] REG_HIGH_LIMIT = 3'd6;
   localparam logic [2:0] REG_LOW_LIMIT  = 3'd7;

   // control from the top level to the hold counters
   typedef struct packed {
      logic toggle_mode;   // selects the short hold length
      logic check;         // this item is a tick that counts
      logic update;        // the item moves to the result register now
   } hold_ctrl_type;

   // one result beat
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        mode;
      logic signed [15:0] speed;
      logic [15:0]       limit;
      logic [1:0]        flag;
      logic [1:0]        state;
   } result_type;

endpackage

// File: rtl/tlds_hold.sv
// sustained high and low current detection with two saturating hold counters
module tlds_hold (
   input  logic                  clock,
   input  logic                  reset,
   input  tlds_pkg::hold_ctrl_type ctrl,
   input  logic signed [15:0]    current_ma,
   input  logic [15:0]           high_limit,
   input  logic [15:0]           low_limit,
   output logic [1:0]            flag
);
   import tlds_pkg::*;

   logic [CNT_W-1:0] high_count_ff, high_count_in;
   logic [CNT_W-1:0] low_count_ff, low_count_in;
   logic [CNT_W-1:0] hold;
   logic [CNT_W-1:0] high_nx, low_nx;
   logic [1:0]       flag_raw;

   logic signed [16:0] cur_ext, hi_ext, lo_ext;
   logic signed [28:0] cur_scaled, neg_hi, neg_lo;
   logic [26:0]        hi_prod, lo_prod;
   logic               is_high, is_low;

   assign hold = ctrl.toggle_mode ? HOLD_TICKS_TOGGLE : HOLD_TICKS_SPEED;

   // exact compare of c against -(limit * 1066 / 1024) as c * 1024 against -(limit * 1066)
   assign cur_ext    = {current_ma[15], current_ma};
   assign hi_ext     = $signed({1'b0, high_limit});
   assign lo_ext     = $signed({1'b0, low_limit});
   assign cur_scaled = $signed({{3{current_ma[15]}}, current_ma, {NEG_SHIFT{1'b0}}});
   assign hi_prod    = 27'(high_limit) * 27'(NEG_SCALE);
   assign lo_prod    = 27'(low_limit) * 27'(NEG_SCALE);
   assign neg_hi     = -$signed({2'b00, hi_prod});
   assign neg_lo     = -$signed({2'b00, lo_prod});

   assign is_high = (cur_ext > hi_ext) || (cur_scaled < neg_hi);
   assign is_low  = (cur_ext < lo_ext) && (cur_scaled > neg_lo);

   // high side first; the low side counts on from the low count as the high side left it, and wins a tie
   always_comb begin
      high_nx  = high_count_ff;
      low_nx   = low_count_ff;
      flag_raw = FLAG_NONE;
      if (is_high) begin
         high_nx = high_count_ff + 12'd1;
         if (high_nx >= hold) begin
            high_nx  = hold;
            low_nx   = '0;
            flag_raw = FLAG_HIGH;
         end
      end
      if (is_low) begin
         low_nx = low_nx + 12'd1;
         if (low_nx >= hold) begin
            low_nx   = hold;
            high_nx  = '0;
            flag_raw = FLAG_LOW;
         end
      end
   end

   assign flag = ctrl.check ? flag_raw : FLAG_NONE;

   always_comb begin
      high_count_in = high_count_ff;
      low_count_in  = low_count_ff;
      if (ctrl.check && ctrl.update) begin
         high_count_in = high_nx;
         low_count_in  = low_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_count_ff <= '0;
         low_count_ff  <= '0;
      end else begin
         high_count_ff <= high_count_in;
         low_count_ff  <= low_count_in;
      end
   end

   // a sustained low clears the high count
   a_low_clears_high: assert property (@(posedge clock) disable iff (reset)
      ctrl.update && flag == FLAG_LOW |=> high_count_ff == '0)
      else $error("high count not cleared after sustained low");

   // a sustained high leaves the high count at the hold length
   a_high_saturates: assert property (@(posedge clock) disable iff (reset)
      ctrl.update && flag == FLAG_HIGH |=> high_count_ff == $past(hold))
      else $error("high count not at hold length after sustained high");

   // counters move only on counting ticks
   a_counts_idle: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.check && ctrl.update) |=> $stable(high_count_ff) && $stable(low_count_ff))
      else $error("hold counters changed without a counting tick");

endmodule

// File: rtl/tlds_dir.sv
// direction decision: next run status and the command for one item
module tlds_dir (
   input  logic [1:0]          op,
   input  logic [2:0]          run_mode,
   input  logic [1:0]          status,
   input  logic [1:0]          flag,
   input  logic                sum_pos,
   input  logic                sum_neg,
   input  logic signed [15:0]  fwd_speed,
   input  logic signed [15:0]  rev_speed,
   input  logic signed [15:0]  osc_speed,
   input  logic [15:0]         high_limit,
   output tlds_pkg::result_type result
);
   import tlds_pkg::*;

   logic              go;
   logic [1:0]        go_state;
   logic              negate;
   logic signed [15:0] sp;
   logic [1:0]        drv;
   logic [1:0]        kind;
   logic [1:0]        state_nx;

   always_comb begin
      go       = 1'b0;
      go_state = ST_STOP;
      negate   = 1'b0;
      sp       = '0;
      drv      = DRV_SPEED;
      kind     = CMD_NONE;
      state_nx = status;
      unique case (op)
         OP_START: begin
            state_nx = ST_START;
         end
         OP_STOP: begin
            state_nx = ST_STOP;
            kind     = CMD_STOP;
         end
         OP_TICK: begin
            unique case (run_mode)
               MODE_TOGGLE: begin
                  sp = osc_speed;
                  if (status == ST_START) begin
                     go       = 1'b1;
                     go_state = sum_neg ? ST_REV : ST_FWD;
                     negate   = sum_neg;
                     drv      = DRV_TOGGLE;
                  end else if (status == ST_FWD) begin
                     if ((flag == FLAG_LOW && sum_neg) || (flag == FLAG_HIGH && sum_pos)) begin
                        go       = 1'b1;
                        go_state = ST_REV;
                        negate   = 1'b1;
                     end
                  end else if (status == ST_REV) begin
                     if ((flag == FLAG_LOW && sum_pos) || (flag == FLAG_HIGH && sum_neg)) begin
                        go       = 1'b1;
                        go_state = ST_FWD;
                     end
                  end
               end
               MODE_SPD_REV: begin
                  sp = rev_speed;
                  if (status == ST_START) begin
                     go       = 1'b1;
                     go_state = ST_REV;
                  end else if (status == ST_REV && flag == FLAG_HIGH) begin
                     go       = 1'b1;
                     go_state = ST_FWD;
                     negate   = 1'b1;
                  end else if (status == ST_FWD && flag == FLAG_LOW) begin
                     go       = 1'b1;
                     go_state = ST_REV;
                  end
               end
               MODE_SPD_FWD: begin
                  sp = fwd_speed;
                  if (status == ST_START) begin
                     go       = 1'b1;
                     go_state = ST_FWD;
                  end else if (status == ST_FWD && flag == FLAG_HIGH) begin
                     go       = 1'b1;
                     go_state = ST_REV;
                     negate   = 1'b1;
                  end else if (status == ST_REV && flag == FLAG_LOW) begin
                     go       = 1'b1;
                     go_state = ST_FWD;
                  end
               end
               MODE_KEEP_FWD: begin
                  sp = fwd_speed;
                  if (status == ST_START) begin
                     go       = 1'b1;
                     go_state = ST_FWD;
                  end else if (status == ST_FWD && flag == FLAG_HIGH) begin
                     state_nx = ST_STOP;
                     kind     = CMD_STOP;
                  end
               end
               MODE_KEEP_REV: begin
                  sp = rev_speed;
                  if (status == ST_START) begin
                     go       = 1'b1;
                     go_state = ST_REV;
                  end else if (status == ST_REV && flag == FLAG_HIGH) begin
                     state_nx = ST_STOP;
                     kind     = CMD_STOP;
                  end
               end
               default: begin
               end
            endcase
            if (go) begin
               state_nx = go_state;
               kind     = CMD_RUN;
            end
         end
         default: begin
         end
      endcase
   end

   // run fields stay zero unless a run command goes out
   always_comb begin
      result.kind  = kind;
      result.mode  = go ? drv : DRV_SPEED;
      result.speed = go ? (negate ? -sp : sp) : '0;
      result.limit = go ? high_limit : '0;
      result.flag  = flag;
      result.state = state_nx;
   end

endmodule

// File: rtl/torque_limited_direction_sequencer.sv
// top level of the torque limited direction sequencer
// an item goes through the input register and the result register, with compare, count
//    and direction logic between them; one beat per cycle while the response is not stalled
// the request side is stalled only while the input register is full and the result register is full and stalled
// reset (synchronous, active high) empties both registers, stops the motor state,
//    clears the hold counters and loads the register reset values
module torque_limited_direction_sequencer (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_current_ma,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_cmd_kind,
   output logic [1:0]         rsp_cmd_mode,
   output logic signed [15:0] rsp_cmd_speed,
   output logic [15:0]        rsp_cmd_limit,
   output logic [1:0]         rsp_reach_flag,
   output logic [1:0]         rsp_run_state,
   // register write port
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import tlds_pkg::*;

   // configuration registers
   logic [2:0]         run_mode_ff;
   logic signed [15:0] fwd_speed_ff, rev_speed_ff, osc_speed_ff;
   logic signed [15:0] fwd_target_ff, rev_target_ff;
   logic [15:0]        high_limit_ff, low_limit_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_op_ff;
   logic signed [15:0] in_cur_ff;

   // motor state
   logic [1:0]         status_ff, status_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff;

   logic               out_free;
   logic               advance;
   logic               req_take;
   logic signed [16:0] target_sum;
   logic               sum_pos, sum_neg;
   logic               toward_larger;
   hold_ctrl_type      hold_ctrl;
   logic [1:0]         flag;
   result_type         result;

   // handshake: result register frees when empty or taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // config beats, to be sent only while idle; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         run_mode_ff   <= MODE_SPD_FWD;
         fwd_speed_ff  <= '0;
         rev_speed_ff  <= '0;
         osc_speed_ff  <= '0;
         fwd_target_ff <= '0;
         rev_target_ff <= '0;
         high_limit_ff <= '0;
         low_limit_ff  <= LOW_LIMIT_MIN;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RUN_MODE:   run_mode_ff   <= csr_wdata[2:0];
            REG_FWD_SPEED:  fwd_speed_ff  <= csr_wdata;
            REG_REV_SPEED:  rev_speed_ff  <= csr_wdata;
            REG_OSC_SPEED:  osc_speed_ff  <= csr_wdata;
            REG_FWD_TARGET: fwd_target_ff <= csr_wdata;
            REG_REV_TARGET: rev_target_ff <= csr_wdata;
            REG_HIGH_LIMIT: high_limit_ff <= csr_wdata;
            // lower threshold never goes below its floor
            REG_LOW_LIMIT:  low_limit_ff  <= (csr_wdata < LOW_LIMIT_MIN) ? LOW_LIMIT_MIN
                                                                         : csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff  <= req_op;
         in_cur_ff <= req_current_ma;
      end
   end

   // the sign of the 17 bit target sum, and whether it is zero, steers direction
   assign target_sum = 17'(fwd_target_ff) + 17'(rev_target_ff);
   assign sum_neg    = target_sum[16];
   assign sum_pos    = !target_sum[16] && (target_sum != '0);

   // toggle mode counts only while heading for the larger target
   assign toward_larger = (sum_pos && status_ff == ST_FWD) || (sum_neg && status_ff == ST_REV);

   assign hold_ctrl.toggle_mode = (run_mode_ff == MODE_TOGGLE);
   assign hold_ctrl.check       = (in_op_ff == OP_TICK) &&
                                  ((run_mode_ff != MODE_TOGGLE) || toward_larger);
   assign hold_ctrl.update      = advance;

   tlds_hold u_hold (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (hold_ctrl),
      .current_ma (in_cur_ff),
      .high_limit (high_limit_ff),
      .low_limit  (low_limit_ff),
      .flag       (flag)
   );

   tlds_dir u_dir (
      .op         (in_op_ff),
      .run_mode   (run_mode_ff),
      .status     (status_ff),
      .flag       (flag),
      .sum_pos    (sum_pos),
      .sum_neg    (sum_neg),
      .fwd_speed  (fwd_speed_ff),
      .rev_speed  (rev_speed_ff),
      .osc_speed  (osc_speed_ff),
      .high_limit (high_limit_ff),
      .result     (result)
   );

   // motor state moves with each item that reaches the result register
   assign status_in = advance ? result.state : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_STOP;
      end else begin
         status_ff <= status_in;
      end
   end

   // result register
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cmd_kind   = out_ff.kind;
   assign rsp_cmd_mode   = out_ff.mode;
   assign rsp_cmd_speed  = out_ff.speed;
   assign rsp_cmd_limit  = out_ff.limit;
   assign rsp_reach_flag = out_ff.flag;
   assign rsp_run_state  = out_ff.state;

   // an item leaving the input register always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("item lost between input and result register");

   // run fields are zero on beats without a run command
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind != CMD_RUN |->
         out_ff.mode == DRV_SPEED && out_ff.speed == '0 && out_ff.limit == '0)
      else $error("run fields set without a run command");

   // a stop command always leaves the motor stopped
   a_stop_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == CMD_STOP |-> out_ff.state == ST_STOP)
      else $error("stop command with motor not stopped");

   // the reported state is the state the next item starts from
   a_state_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> status_ff == out_ff.state)
      else $error("motor state and reported state disagree");

endmodule

// File: verif/tb_top.sv
// self-checking testbench of the torque limited direction sequencer
`timescale 1ns / 100ps

module tb_top;
   import tlds_pkg::*;

   localparam int          CLOCK_HALF    = 6;
   localparam int          RESET_CYCLES  = 9;
   localparam int          EPISODES      = 6;
   localparam int          LONG_HOLD_OFF = 60;
   localparam int          SETTLE_CYCLES = 3;
   localparam int          CYCLE_LIMIT   = 100000;
   localparam int          MAX_REPORTS   = 10;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [2:0]  MODE_LAST     = 3'd7;

   // what kind of current sample a tick should carry
   typedef enum int {SAMPLE_ANY, SAMPLE_HIGH, SAMPLE_LOW, SAMPLE_MID} sample_kind_type;

   // predicts one response beat per request beat and checks the block against it
   class direction_scoreboard_type;
      logic [2:0]         run_mode;
      logic signed [15:0] fwd_speed, rev_speed, osc_speed, fwd_target, rev_target;
      logic [15:0]        high_limit, low_limit;
      logic [1:0]         status;
      logic [CNT_W-1:0]   high_cnt, low_cnt;
      result_type         due_commands[$];
      int                 mismatches, requests, responses;
      int                 run_cmds, stop_cmds, high_flags, low_flags;

      function new();
         run_mode   = MODE_SPD_FWD;
         fwd_speed  = '0;
         rev_speed  = '0;
         osc_speed  = '0;
         fwd_target = '0;
         rev_target = '0;
         high_limit = '0;
         low_limit  = LOW_LIMIT_MIN;
         status     = ST_STOP;
         high_cnt   = '0;
         low_cnt    = '0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            REG_RUN_MODE:   run_mode   = data[2:0];
            REG_FWD_SPEED:  fwd_speed  = data;
            REG_REV_SPEED:  rev_speed  = data;
            REG_OSC_SPEED:  osc_speed  = data;
            REG_FWD_TARGET: fwd_target = data;
            REG_REV_TARGET: rev_target = data;
            REG_HIGH_LIMIT: high_limit = data;
            REG_LOW_LIMIT:  low_limit  = (data < LOW_LIMIT_MIN) ? LOW_LIMIT_MIN : data;
            default: ;
         endcase
      endfunction

      // negative side thresholds are scaled by 1066/1024, compared exactly
      function bit over_high(logic signed [15:0] cur);
         longint c, lim;
         c   = cur;
         lim = high_limit;
         return (c > lim) || (c * 1024 < -(lim * 1066));
      endfunction

      function bit under_low(logic signed [15:0] cur);
         longint c, lim;
         c   = cur;
         lim = low_limit;
         return (c < lim) && (c * 1024 > -(lim * 1066));
      endfunction

      // saturating hold counters; a low sample is looked at after a high one
      function logic [1:0] count_hold(logic signed [15:0] cur, logic [CNT_W-1:0] hold);
         logic [1:0] flag;
         flag = FLAG_NONE;
         if (over_high(cur)) begin
            high_cnt = high_cnt + 1'b1;
            if (high_cnt >= hold) begin
               high_cnt = hold;
               low_cnt  = '0;
               flag     = FLAG_HIGH;
            end
         end
         if (under_low(cur)) begin
            low_cnt = low_cnt + 1'b1;
            if (low_cnt >= hold) begin
               low_cnt  = hold;
               high_cnt = '0;
               flag     = FLAG_LOW;
            end
         end
         return flag;
      endfunction

      function void note_request(logic [1:0] op, logic signed [15:0] cur);
         result_type         res;
         logic [1:0]         heading;
         logic signed [15:0] spd;
         bit                 flip;
         int                 target_sum;
         res        = '0;
         heading    = ST_STOP;
         spd        = '0;
         flip       = 1'b0;
         target_sum = int'(fwd_target) + int'(rev_target);
         requests++;
         if (op == OP_START) begin
            status = ST_START;
         end else if (op == OP_STOP) begin
            status   = ST_STOP;
            res.kind = CMD_STOP;
         end else if (op == OP_TICK) begin
            // toggle mode counts only while heading for the larger target
            if (run_mode == MODE_TOGGLE) begin
               if ((target_sum > 0 && status == ST_FWD) || (target_sum < 0 && status == ST_REV))
                  res.flag = count_hold(cur, HOLD_TICKS_TOGGLE);
            end else begin
               res.flag = count_hold(cur, HOLD_TICKS_SPEED);
            end
            case (run_mode)
               MODE_TOGGLE: begin
                  spd = osc_speed;
                  if (status == ST_START) begin
                     heading  = (target_sum < 0) ? ST_REV : ST_FWD;
                     flip     = (target_sum < 0);
                     res.mode = DRV_TOGGLE;
                  end else if (status == ST_FWD) begin
                     if ((res.flag == FLAG_LOW && target_sum < 0) ||
                         (res.flag == FLAG_HIGH && target_sum > 0)) begin
                        heading = ST_REV;
                        flip    = 1'b1;
                     end
                  end else if (status == ST_REV) begin
                     if ((res.flag == FLAG_LOW && target_sum > 0) ||
                         (res.flag == FLAG_HIGH && target_sum < 0))
                        heading = ST_FWD;
                  end
               end
               MODE_SPD_REV: begin
                  spd = rev_speed;
                  if (status == ST_START) heading = ST_REV;
                  else if (status == ST_REV && res.flag == FLAG_HIGH) begin
                     heading = ST_FWD;
                     flip    = 1'b1;
                  end else if (status == ST_FWD && res.flag == FLAG_LOW) heading = ST_REV;
               end
               MODE_SPD_FWD: begin
                  spd = fwd_speed;
                  if (status == ST_START) heading = ST_FWD;
                  else if (status == ST_FWD && res.flag == FLAG_HIGH) begin
                     heading = ST_REV;
                     flip    = 1'b1;
                  end else if (status == ST_REV && res.flag == FLAG_LOW) heading = ST_FWD;
               end
               MODE_KEEP_FWD: begin
                  spd = fwd_speed;
                  if (status == ST_START) heading = ST_FWD;
                  else if (status == ST_FWD && res.flag == FLAG_HIGH) begin
                     status   = ST_STOP;
                     res.kind = CMD_STOP;
                  end
               end
               MODE_KEEP_REV: begin
                  spd = rev_speed;
                  if (status == ST_START) heading = ST_REV;
                  else if (status == ST_REV && res.flag == FLAG_HIGH) begin
                     status   = ST_STOP;
                     res.kind = CMD_STOP;
                  end
               end
               default: ;
            endcase
            if (heading != ST_STOP) begin
               status    = heading;
               res.kind  = CMD_RUN;
               res.speed = flip ? -spd : spd;
               res.limit = high_limit;
            end else begin
               res.mode = DRV_SPEED;
            end
         end
         res.state = status;
         if (res.kind == CMD_RUN) run_cmds++;
         if (res.kind == CMD_STOP) stop_cmds++;
         if (res.flag == FLAG_HIGH) high_flags++;
         if (res.flag == FLAG_LOW) low_flags++;
         due_commands.push_back(res);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (due_commands.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response beat with nothing due: kind %0d state %0d",
                        $time, got.kind, got.state);
            return;
         end
         want = due_commands.pop_front();
         responses++;
         if (got.kind !== want.kind || got.mode !== want.mode || got.speed !== want.speed ||
             got.limit !== want.limit || got.flag !== want.flag || got.state !== want.state) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: beat %0d exp/got kind %0d/%0d mode %0d/%0d speed %0d/%0d",
                        $time, responses, want.kind, got.kind, want.mode, got.mode,
                        want.speed, got.speed,
                        "  limit %0d/%0d flag %0d/%0d state %0d/%0d",
                        want.limit, got.limit, want.flag, got.flag, want.state, got.state);
         end
      endfunction

      function int pending();
         return due_commands.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_op;
   logic signed [15:0] req_current_ma;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_cmd_kind;
   logic [1:0]         rsp_cmd_mode;
   logic signed [15:0] rsp_cmd_speed;
   logic [15:0]        rsp_cmd_limit;
   logic [1:0]         rsp_reach_flag;
   logic [1:0]         rsp_run_state;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   direction_scoreboard_type sb;
   bit sender_gaps      = 1'b1;
   bit rsp_gaps         = 1'b1;
   bit hold_off_pending = 1'b0;
   int hold_offs        = 0;
   int cycles           = 0;

   torque_limited_direction_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_current_ma (req_current_ma),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cmd_kind   (rsp_cmd_kind),
      .rsp_cmd_mode   (rsp_cmd_mode),
      .rsp_cmd_speed  (rsp_cmd_speed),
      .rsp_cmd_limit  (rsp_cmd_limit),
      .rsp_reach_flag (rsp_reach_flag),
      .rsp_run_state  (rsp_run_state),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #CLOCK_HALF clock = ~clock;

   // run limit in case the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // accepted request beats feed the prediction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_op, req_current_ma);
   end

   // accepted response beats are checked in order
   always @(posedge clock) begin : response_monitor
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind  = rsp_cmd_kind;
         got.mode  = rsp_cmd_mode;
         got.speed = rsp_cmd_speed;
         got.limit = rsp_cmd_limit;
         got.flag  = rsp_reach_flag;
         got.state = rsp_run_state;
         sb.check_response(got);
      end
   end

   // response side: random stall bursts, plus a long hold-off on request
   initial begin : response_side
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_OFF) @(negedge clock);
            hold_off_pending = 1'b0;
            hold_offs++;
            rsp_stall <= 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_item(logic [1:0] op, logic signed [15:0] cur);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_current_ma <= cur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // register writes only while nothing is in flight
   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // current sample of the wanted kind, near a threshold or anywhere
   function automatic logic signed [15:0] draw_current(sample_kind_type want);
      int                 hi, lo, cand;
      logic signed [15:0] s;
      hi = sb.high_limit;
      lo = sb.low_limit;
      s  = 16'($urandom);
      if (want == SAMPLE_ANY) return s;
      for (int k = 0; k < 64; k++) begin
         case ($urandom_range(0, 5))
            0:       cand = hi;
            1:       cand = -((hi * 1066) >>> 10);
            2:       cand = lo;
            3:       cand = -((lo * 1066) >>> 10);
            4:       cand = 0;
            default: cand = int'($signed(16'($urandom)));
         endcase
         cand = cand + int'($urandom_range(0, 80)) - 40;
         if (cand < -32768 || cand > 32767) continue;
         s = 16'(cand);
         case (want)
            SAMPLE_HIGH: if (sb.over_high(s)) return s;
            SAMPLE_LOW:  if (sb.under_low(s)) return s;
            default:     if (!sb.over_high(s) && !sb.under_low(s)) return s;
         endcase
      end
      return s;
   endfunction

   task automatic send_noise(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 19);
         if (r < 15) send_item(OP_TICK, draw_current(sample_kind_type'($urandom_range(0, 3))));
         else if (r < 17) send_item(OP_START, 16'($urandom));
         else if (r < 18) send_item(OP_STOP, 16'($urandom));
         else send_item(OP_UNUSED, 16'($urandom));
      end
   endtask

   // sustained ticks of one kind, with an occasional stray sample
   task automatic send_run(int count, sample_kind_type want);
      repeat (count)
         send_item(OP_TICK, draw_current(($urandom_range(0, 19) == 0) ? SAMPLE_ANY : want));
   endtask

   task automatic configure_episode(bit long_run);
      logic [2:0]  mode;
      logic [15:0] hi, lo, fwd_tgt, rev_tgt;
      int          r;
      r = $urandom_range(0, 11);
      if (long_run || r < 5) mode = MODE_TOGGLE;
      else if (r < 10) mode = 3'($urandom_range(MODE_SPD_REV, MODE_KEEP_REV));
      else mode = 3'($urandom_range(MODE_KEEP_REV + 1, MODE_LAST));
      case ($urandom_range(0, 7))
         0:       hi = '0;
         1:       hi = 16'hFFFF;
         2:       hi = 16'($urandom);
         default: hi = 16'($urandom_range(1, 4000));
      endcase
      case ($urandom_range(0, 7))
         0:       lo = 16'($urandom_range(0, LOW_LIMIT_MIN - 1));
         1:       lo = 16'hFFFF;
         2:       lo = 16'($urandom);
         default: lo = 16'($urandom_range(LOW_LIMIT_MIN, 1500));
      endcase
      fwd_tgt = 16'($urandom);
      rev_tgt = ($urandom_range(0, 5) == 0) ? -fwd_tgt : 16'($urandom);
      // long episodes head forward toward the larger target so the toggle hold counts
      if (long_run) begin
         hi      = 16'($urandom_range(0, 4000));
         lo      = 16'($urandom_range(0, 300));
         fwd_tgt = 16'($urandom_range(1, 32767));
         rev_tgt = 16'($urandom_range(0, 32767));
      end
      // upper bits of the mode word are don't care
      write_reg(REG_RUN_MODE, ($urandom_range(0, 3) == 0) ? {13'($urandom), mode} : {13'd0, mode});
      write_reg(REG_FWD_SPEED, ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom));
      write_reg(REG_REV_SPEED, ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom));
      write_reg(REG_OSC_SPEED, ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom));
      write_reg(REG_FWD_TARGET, fwd_tgt);
      write_reg(REG_REV_TARGET, rev_tgt);
      write_reg(REG_HIGH_LIMIT, hi);
      write_reg(REG_LOW_LIMIT, lo);
      csr_we <= 1'b0;
   endtask

   task automatic run_episode(bit long_run, bit hold_off);
      send_item(OP_START, draw_current(SAMPLE_ANY));
      if (hold_off) hold_off_pending = 1'b1;
      send_noise($urandom_range(5, 15));
      if (long_run) begin
         // long enough to saturate the toggle hold counter
         send_item(OP_START, draw_current(SAMPLE_ANY));
         repeat (HOLD_TICKS_TOGGLE + $urandom_range(5, 20))
            send_item(OP_TICK, draw_current(SAMPLE_HIGH));
      end else if (sb.run_mode == MODE_TOGGLE) begin
         repeat (2) begin
            send_item(OP_START, draw_current(SAMPLE_ANY));
            send_run($urandom_range(10, 25), $urandom_range(0, 1) ? SAMPLE_HIGH : SAMPLE_LOW);
         end
      end else begin
         send_run($urandom_range(15, 40), sample_kind_type'($urandom_range(1, 3)));
      end
      send_noise($urandom_range(5, 12));
   endtask

   initial begin : stimulus
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_TICK;
      req_current_ma = '0;
      csr_we         = 1'b0;
      csr_index      = REG_RUN_MODE;
      csr_wdata      = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // register reset values: unused op, ticks while stopped, start then first tick
      send_item(OP_UNUSED, 16'sh8000);
      send_item(OP_TICK, 16'sh7FFF);
      send_item(OP_TICK, 16'sh8000);
      send_item(OP_START, 16'sh0000);
      send_item(OP_TICK, 16'sh0000);
      wait_drain();

      // speed reverse start with extreme speeds, widest target sum, low limit floor
      write_reg(REG_RUN_MODE, {13'd0, MODE_SPD_REV});
      write_reg(REG_FWD_SPEED, 16'h8000);
      write_reg(REG_REV_SPEED, 16'h7FFF);
      write_reg(REG_OSC_SPEED, 16'h8001);
      write_reg(REG_FWD_TARGET, 16'h7FFF);
      write_reg(REG_REV_TARGET, 16'h7FFF);
      write_reg(REG_HIGH_LIMIT, 16'hFFFF);
      write_reg(REG_LOW_LIMIT, 16'd5);
      csr_we <= 1'b0;
      send_item(OP_START, 16'sh7FFF);
      send_item(OP_TICK, 16'sh8000);
      send_item(OP_STOP, 16'sh0001);
      send_item(OP_TICK, 16'sh7FFF);
      wait_drain();

      // toggle start toward the negative target: negating the most negative speed
      write_reg(REG_RUN_MODE, {13'd0, MODE_TOGGLE});
      write_reg(REG_OSC_SPEED, 16'h8000);
      write_reg(REG_FWD_TARGET, 16'h8000);
      write_reg(REG_REV_TARGET, 16'h8000);
      write_reg(REG_HIGH_LIMIT, 16'h0000);
      write_reg(REG_LOW_LIMIT, 16'hFFFF);
      csr_we <= 1'b0;
      send_item(OP_START, 16'sh0000);
      send_item(OP_TICK, 16'sh8000);
      send_item(OP_TICK, 16'sh0001);
      send_item(OP_TICK, -16'sh0001);
      send_item(OP_STOP, 16'sh0000);
      send_item(OP_TICK, 16'sh0000);
      send_item(OP_START, 16'sh0000);
      send_item(OP_TICK, 16'sh7FFF);
      wait_drain();

      // unused run mode via a mode word with all bits set, low limit written as zero and held at its floor
      write_reg(REG_RUN_MODE, 16'hFFFF);
      write_reg(REG_LOW_LIMIT, 16'h0000);
      csr_we <= 1'b0;
      send_item(OP_START, 16'sh0000);
      send_item(OP_TICK, 16'sh0064);
      send_item(OP_TICK, -16'sh0064);
      send_item(OP_STOP, 16'sh0000);
      send_item(OP_UNUSED, 16'sh7FFF);

      // random episodes, each with its own register setting
      for (int ep = 0; ep < EPISODES; ep++) begin
         if (ep >= EPISODES - 2) begin
            sender_gaps = 1'b0;
            rsp_gaps    = 1'b0;
         end
         wait_drain();
         configure_episode(ep == 3);
         run_episode(ep == 3, ep == 1 || ep == 2);
      end

      wait_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("summary: %0d request and %0d response beats over %0d episodes, %0d hold-offs",
               sb.requests, sb.responses, EPISODES, hold_offs);
      $display("summary: %0d run and %0d stop commands, %0d high and %0d low flags, %0d bad",
               sb.run_cmds, sb.stop_cmds, sb.high_flags, sb.low_flags, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
